// ===== sv/bqm_pkg.sv =====
// Shared constants, types and codes of the banked queued memory.
`default_nettype none
package bqm_pkg;

   // Field widths of the item ports
   localparam int OPCODE_W = 2;
   localparam int REQ_ID_W = 2;
   localparam int WADDR_W  = 12;
   localparam int WORD_W   = 64;

   // Block configuration
   localparam int BANKS        = 4;
   localparam int QUEUE_LEN    = 4;
   localparam int ACCESS_DELAY = 4;
   localparam int ADDR_BITS    = 12;

   localparam int MEM_WORDS  = 1 << ADDR_BITS;
   localparam int BANK_W     = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int PTR_W      = $clog2(QUEUE_LEN);
   localparam int COUNT_W    = $clog2(QUEUE_LEN + 1);
   localparam int FIFO_DEPTH = BANKS * QUEUE_LEN;
   localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);

   typedef logic [OPCODE_W-1:0]   opcode_type;
   typedef logic [REQ_ID_W-1:0]   req_id_type;
   typedef logic [WADDR_W-1:0]    waddr_type;
   typedef logic [WORD_W-1:0]     word_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [BANK_W-1:0]     bank_type;
   typedef logic [PTR_W-1:0]      ptr_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [FIFO_IDX_W-1:0] fifo_idx_type;

   // Opcodes of an input item
   localparam opcode_type OP_READ  = 2'd0;
   localparam opcode_type OP_WRITE = 2'd1;
   localparam opcode_type OP_TICK  = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear;      // zero one memory word of the clearing pass
      logic enqueue;    // push the request into its bank queue
      logic enq_write;  // the pushed request is a write
      logic tick;       // arbitrate and pop one queued request
      logic serve;      // access the memory for the popped request
      logic finish;     // advance the delay line and form the tick result
      logic load_rsp;   // capture the result into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last; // last word of the clearing pass is being written
   } stat_type;

   // One result item
   typedef struct packed {
      logic       status;
      logic       ack_valid;
      req_id_type ack_requester;
      word_type   read_word;
   } result_type;

endpackage
`default_nettype wire

// ===== sv/bqm_ctrl.sv =====
// Controller state machine: clearing pass, item acceptance and tick sequencing.
`default_nettype none
module bqm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire bqm_pkg::opcode_type req_opcode,
   input  wire logic               rsp_stall,
   input  wire bqm_pkg::stat_type  dp_stat,
   output logic                    req_stall,
   output logic                    rsp_valid,
   output bqm_pkg::cmd_type        cmd
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_SERVE  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      req_stall    = !((state_ff == ST_IDLE) && out_free);
      accept       = req_valid && !req_stall;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (dp_stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == bqm_pkg::OP_TICK) begin
                  cmd.tick = 1'b1;
                  state_in = ST_SERVE;
               end else begin
                  cmd.enqueue   = (req_opcode == bqm_pkg::OP_READ) ||
                                  (req_opcode == bqm_pkg::OP_WRITE);
                  cmd.enq_write = (req_opcode == bqm_pkg::OP_WRITE);
                  cmd.load_rsp  = 1'b1;
               end
            end
         end
         ST_SERVE: begin
            cmd.serve = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish   = 1'b1;
            cmd.load_rsp = 1'b1;
            state_in     = ST_IDLE;
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The tick result must land in an empty output register.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> !rsp_valid_ff)
      else $error("tick result would overwrite a pending result");

   // No item may be taken while the memory is being cleared.
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall)
      else $error("item accepted during clearing pass");

   // An accepted tick walks through serve and finish in order.
   a_tick_seq: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode == bqm_pkg::OP_TICK |=>
         state_ff == ST_SERVE ##1 state_ff == ST_FINISH)
      else $error("tick sequence broken");

endmodule
`default_nettype wire

// ===== sv/bqm_datapath.sv =====
// Datapath: bank queues, round-robin pick, word memory and read delay line.
`default_nettype none
module bqm_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bqm_pkg::cmd_type    cmd,
   input  wire bqm_pkg::req_id_type req_requester,
   input  wire bqm_pkg::waddr_type  req_word_address,
   input  wire bqm_pkg::word_type   req_write_word,
   output bqm_pkg::stat_type        stat,
   output bqm_pkg::result_type      result
);

   // Bank queue storage
   bqm_pkg::addr_type  fifo_addr_ff  [bqm_pkg::FIFO_DEPTH];
   bqm_pkg::word_type  fifo_data_ff  [bqm_pkg::FIFO_DEPTH];
   logic               fifo_write_ff [bqm_pkg::FIFO_DEPTH];
   bqm_pkg::ptr_type   head_ff  [bqm_pkg::BANKS];
   bqm_pkg::ptr_type   tail_ff  [bqm_pkg::BANKS];
   bqm_pkg::count_type count_ff [bqm_pkg::BANKS];
   bqm_pkg::bank_type  next_req_ff;

   // Popped request
   logic               srv_valid_ff;
   logic               srv_write_ff;
   bqm_pkg::bank_type  srv_bank_ff;
   bqm_pkg::addr_type  srv_addr_ff;
   bqm_pkg::word_type  srv_data_ff;

   // Word memory and its clearing pass
   bqm_pkg::word_type  mem [bqm_pkg::MEM_WORDS];
   bqm_pkg::word_type  mem_rdata_ff;
   bqm_pkg::addr_type  clr_addr_ff;

   bqm_pkg::bank_type     enq_bank;
   logic                  enq_drop;
   bqm_pkg::fifo_idx_type wr_pos;
   bqm_pkg::fifo_idx_type rd_pos;
   logic                  arb_found;
   bqm_pkg::bank_type     arb_sel;
   bqm_pkg::bank_type     arb_next;

   logic                  dly_in_valid;
   logic                  dly_out_valid;
   bqm_pkg::bank_type     dly_out_bank;
   bqm_pkg::word_type     dly_out_word;

   function automatic bqm_pkg::ptr_type ptr_inc(input bqm_pkg::ptr_type p);
      if (int'(p) == bqm_pkg::QUEUE_LEN - 1) begin
         return '0;
      end
      return bqm_pkg::ptr_type'(int'(p) + 1);
   endfunction

   function automatic bqm_pkg::bank_type bank_inc(input bqm_pkg::bank_type b);
      if (int'(b) >= bqm_pkg::BANKS - 1) begin
         return '0;
      end
      return bqm_pkg::bank_type'(int'(b) + 1);
   endfunction

   // Enqueue side
   always_comb begin
      enq_bank = bqm_pkg::bank_type'(req_requester);
      enq_drop = (int'(req_requester) >= bqm_pkg::BANKS) ||
                 (int'(count_ff[enq_bank]) >= bqm_pkg::QUEUE_LEN);
      wr_pos   = bqm_pkg::fifo_idx_type'(int'(enq_bank) * bqm_pkg::QUEUE_LEN +
                                         int'(tail_ff[enq_bank]));
   end

   // Round-robin pick, starting at next_req_ff
   always_comb begin
      int idx;
      arb_found = 1'b0;
      arb_sel   = '0;
      for (int i = 0; i < bqm_pkg::BANKS; i++) begin
         idx = int'(next_req_ff) + i;
         if (idx >= bqm_pkg::BANKS) begin
            idx = idx - bqm_pkg::BANKS;
         end
         if (!arb_found && (count_ff[bqm_pkg::bank_type'(idx)] != '0)) begin
            arb_found = 1'b1;
            arb_sel   = bqm_pkg::bank_type'(idx);
         end
      end
      arb_next = arb_found ? bank_inc(arb_sel) : next_req_ff;
      rd_pos   = bqm_pkg::fifo_idx_type'(int'(arb_sel) * bqm_pkg::QUEUE_LEN +
                                         int'(head_ff[arb_sel]));
   end

   always_ff @(posedge clock) begin
      if (cmd.enqueue && !enq_drop) begin
         fifo_addr_ff[wr_pos]  <= bqm_pkg::addr_type'(req_word_address);
         fifo_data_ff[wr_pos]  <= req_write_word;
         fifo_write_ff[wr_pos] <= cmd.enq_write;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < bqm_pkg::BANKS; b++) begin
            head_ff[b]  <= '0;
            tail_ff[b]  <= '0;
            count_ff[b] <= '0;
         end
         next_req_ff  <= '0;
         srv_valid_ff <= 1'b0;
         clr_addr_ff  <= '0;
      end else begin
         if (cmd.enqueue && !enq_drop) begin
            tail_ff[enq_bank]  <= ptr_inc(tail_ff[enq_bank]);
            count_ff[enq_bank] <= count_ff[enq_bank] + 1'b1;
         end
         if (cmd.tick) begin
            if (arb_found) begin
               head_ff[arb_sel]  <= ptr_inc(head_ff[arb_sel]);
               count_ff[arb_sel] <= count_ff[arb_sel] - 1'b1;
            end
            next_req_ff  <= arb_next;
            srv_valid_ff <= arb_found;
         end
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick) begin
         srv_bank_ff  <= arb_sel;
         srv_addr_ff  <= fifo_addr_ff[rd_pos];
         srv_data_ff  <= fifo_data_ff[rd_pos];
         srv_write_ff <= fifo_write_ff[rd_pos];
      end
   end

   // Word memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.serve && srv_valid_ff && srv_write_ff) begin
         mem[srv_addr_ff] <= srv_data_ff;
      end
      if (cmd.serve) begin
         mem_rdata_ff <= mem[srv_addr_ff];
      end
   end

   assign stat.clear_last = cmd.clear && (clr_addr_ff == '1);
   assign dly_in_valid    = srv_valid_ff && !srv_write_ff;

   // Read delay line, advanced once per tick
   generate
      if (bqm_pkg::ACCESS_DELAY == 0) begin : g_no_delay
         assign dly_out_valid = dly_in_valid;
         assign dly_out_bank  = srv_bank_ff;
         assign dly_out_word  = mem_rdata_ff;
      end else begin : g_delay
         logic              dl_valid_ff [bqm_pkg::ACCESS_DELAY];
         bqm_pkg::bank_type dl_bank_ff  [bqm_pkg::ACCESS_DELAY];
         bqm_pkg::word_type dl_word_ff  [bqm_pkg::ACCESS_DELAY];

         always_ff @(posedge clock) begin
            if (reset) begin
               for (int k = 0; k < bqm_pkg::ACCESS_DELAY; k++) begin
                  dl_valid_ff[k] <= 1'b0;
               end
            end else if (cmd.finish) begin
               dl_valid_ff[0] <= dly_in_valid;
               for (int k = 1; k < bqm_pkg::ACCESS_DELAY; k++) begin
                  dl_valid_ff[k] <= dl_valid_ff[k-1];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (cmd.finish) begin
               dl_bank_ff[0] <= srv_bank_ff;
               dl_word_ff[0] <= mem_rdata_ff;
               for (int k = 1; k < bqm_pkg::ACCESS_DELAY; k++) begin
                  dl_bank_ff[k] <= dl_bank_ff[k-1];
                  dl_word_ff[k] <= dl_word_ff[k-1];
               end
            end
         end

         assign dly_out_valid = dl_valid_ff[bqm_pkg::ACCESS_DELAY-1];
         assign dly_out_bank  = dl_bank_ff[bqm_pkg::ACCESS_DELAY-1];
         assign dly_out_word  = dl_word_ff[bqm_pkg::ACCESS_DELAY-1];
      end
   endgenerate

   // Result of the current item
   always_comb begin
      result = '0;
      if (cmd.enqueue) begin
         result.status = enq_drop;
      end else if (cmd.finish && dly_out_valid) begin
         result.ack_valid     = 1'b1;
         result.ack_requester = bqm_pkg::req_id_type'(dly_out_bank);
         result.read_word     = dly_out_word;
      end
   end

endmodule
`default_nettype wire

// ===== sv/banked_queued_memory_rr.sv =====
// Top level of the banked queued memory with round-robin service.
`default_nettype none
// A memory of 4096 64-bit words shared by four requesters. Each item on the
// req_ channel is a read request, a write request or a tick. A request is
// pushed into its requester's queue of four entries; when that queue is full
// the request is dropped and the result item carries status 1. A tick serves
// at most one queued request, picking requesters round-robin starting just
// after the last one served: a write stores its word, a read enters a delay
// line and its word comes out with an acknowledge for its requester on the
// fourth tick after the one that served it. Every item gives exactly one
// result item on the rsp_ channel. Requests and unused opcodes are done in
// the cycle they are accepted; a tick goes through three steps (pick and pop,
// memory access through the write port and the registered read port, delay
// line advance). One item is worked on at a time, and the next is taken as
// soon as the output register is empty or being emptied. After reset the
// memory is cleared one word a cycle; req_stall stays high until it is done.
module banked_queued_memory_rr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire bqm_pkg::opcode_type req_opcode,
   input  wire bqm_pkg::req_id_type req_requester,
   input  wire bqm_pkg::waddr_type  req_word_address,
   input  wire bqm_pkg::word_type   req_write_word,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_status,
   output logic                     rsp_ack_valid,
   output bqm_pkg::req_id_type      rsp_ack_requester,
   output bqm_pkg::word_type        rsp_read_word
);

   bqm_pkg::cmd_type    cmd;
   bqm_pkg::stat_type   dp_stat;
   bqm_pkg::result_type result;
   bqm_pkg::result_type rsp_ff;

   // Sequencing: clearing pass, acceptance, tick steps, output valid
   bqm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .rsp_stall  (rsp_stall),
      .dp_stat    (dp_stat),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   // Queues, arbiter, memory and delay line
   bqm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_requester    (req_requester),
      .req_word_address (req_word_address),
      .req_write_word   (req_write_word),
      .stat             (dp_stat),
      .result           (result)
   );

   // Output register: capture the result, hold it while the sink stalls
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= result;
      end
   end

   assign rsp_status        = rsp_ff.status;
   assign rsp_ack_valid     = rsp_ff.ack_valid;
   assign rsp_ack_requester = rsp_ff.ack_requester;
   assign rsp_read_word     = rsp_ff.read_word;

endmodule
`default_nettype wire
